/* hw/rtl/sqvt_pkg.sv */
package sqvt_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;     // power of two, 256..4096
    localparam int TEX_SIZE_MAX     = 4096;

    localparam int SIN_IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int SIN_LOW_W = 16 - SIN_IDX_W;

    localparam int POS_W   = 24;
    localparam int TC_W    = 21;
    localparam int SIZE_W  = 13;
    localparam int NUM_W   = 16;               // sub-rect edge, signed
    localparam int MAG_W   = 14;
    localparam int QUO_W   = MAG_W + 16 + 1;   // magnitude * 65536 + size/2
    localparam int DIV_PER = 4;                // quotient bits per stage
    localparam int DIV_ST  = (QUO_W + DIV_PER - 1) / DIV_PER;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;
    localparam logic signed [TC_W-1:0]  TC_MAX  = 21'sh0FFFFF;
    localparam logic signed [TC_W-1:0]  TC_MIN  = 21'sh100000;

    typedef enum logic [2:0] {
        REG_ROT_ANGLE      = 3'd0,
        REG_ROT_CENTER_X   = 3'd1,
        REG_ROT_CENTER_Y   = 3'd2,
        REG_SCALE_X        = 3'd3,
        REG_SCALE_Y        = 3'd4,
        REG_SCALE_CENTER_X = 3'd5,
        REG_SCALE_CENTER_Y = 3'd6,
        REG_VERTEX_COLOR   = 3'd7
    } cfg_reg_t;

    typedef logic signed [15:0] sin_tab_t [SINE_TABLE_DEPTH];

    typedef struct packed {
        logic [1:0]              idx;
        logic                    aff;
        logic [31:0]             color;
        logic signed [POS_W-1:0] px_pl;
        logic signed [POS_W-1:0] py_pl;
    } meta_t;

    typedef struct packed {
        logic [1:0]              idx;
        logic [31:0]             color;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
    } vtx_t;

    // Q14 sine, full turn = 65536, odd polynomial folded by quadrant
    function automatic longint qsin(input longint phase);
        longint quad;
        longint x;
        longint t2;
        longint acc;
        longint r;
        quad = (phase & 64'hFFFF) >>> 14;
        x    = phase & 64'h3FFF;
        if ((quad & 1) != 0)
        begin
            x = 16384 - x;
        end
        t2  = (x * x) >>> 14;
        acc = 172271;
        acc = 5027051 - ((t2 * acc) >>> 14);
        acc = 85569306 - ((t2 * acc) >>> 14);
        acc = 693598668 - ((t2 * acc) >>> 14);
        acc = 1686629713 - ((t2 * acc) >>> 14);
        r   = (x * acc + (64'sd1 <<< 29)) >>> 30;
        if (r > 16384)
        begin
            r = 16384;
        end
        return ((quad & 2) != 0) ? -r : r;
    endfunction

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t t;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            t[i] = 16'(qsin(longint'(i) <<< SIN_LOW_W));
        end
        return t;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [59:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 60'(POS_MAX))
        begin
            r = POS_MAX;
        end
        else if (v < 60'(POS_MIN))
        begin
            r = POS_MIN;
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/sqvt_div.sv */
// Pipelined restoring divider: round(|num| * 65536 / size), sign restored, saturated
module sqvt_div
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [sqvt_pkg::NUM_W-1:0]   num,
    input  logic [sqvt_pkg::SIZE_W-1:0]         size,
    output logic signed [sqvt_pkg::TC_W-1:0]    quot
);

    localparam int DW = sqvt_pkg::SIZE_W;
    localparam int QW = sqvt_pkg::QUO_W;
    localparam int ST = sqvt_pkg::DIV_ST;
    localparam int PER = sqvt_pkg::DIV_PER;

    logic [DW-1:0] den_reg [ST];
    logic [DW-1:0] rem_reg [ST];
    logic [QW-1:0] acc_reg [ST];
    logic          neg_reg [ST];
    logic [DW-1:0] den_next [ST];
    logic [DW-1:0] rem_next [ST];
    logic [QW-1:0] acc_next [ST];
    logic          neg_next [ST];

    always_comb
    begin
        logic [DW-1:0]                 d;
        logic [DW-1:0]                 r;
        logic [DW:0]                   t;
        logic [QW-1:0]                 a;
        logic                          ng;
        logic [DW-1:0]                 sz;
        logic [sqvt_pkg::MAG_W-1:0]    mag;
        sz = size;
        if (size == '0)
        begin
            sz = DW'(1);
        end
        else if (int'(size) > sqvt_pkg::TEX_SIZE_MAX)
        begin
            sz = DW'(sqvt_pkg::TEX_SIZE_MAX);
        end
        mag = num[sqvt_pkg::NUM_W-1] ? sqvt_pkg::MAG_W'(-num) : sqvt_pkg::MAG_W'(num);
        for (int i = 0; i < ST; i++)
        begin
            if (i == 0)
            begin
                d  = sz;
                r  = '0;
                a  = QW'({mag, 16'h0000}) + QW'(sz >> 1);
                ng = num[sqvt_pkg::NUM_W-1];
            end
            else
            begin
                d  = den_reg[i-1];
                r  = rem_reg[i-1];
                a  = acc_reg[i-1];
                ng = neg_reg[i-1];
            end
            for (int j = 0; j < PER; j++)
            begin
                if (i * PER + j < QW)
                begin
                    t = {r, a[QW-1]};
                    a = {a[QW-2:0], 1'b0};
                    if (t >= {1'b0, d})
                    begin
                        t    = t - {1'b0, d};
                        a[0] = 1'b1;
                    end
                    r = t[DW-1:0];
                end
            end
            den_next[i] = d;
            rem_next[i] = r;
            acc_next[i] = a;
            neg_next[i] = ng;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_next;
            rem_reg <= rem_next;
            acc_reg <= acc_next;
            neg_reg <= neg_next;
        end
    end

    always_comb
    begin
        logic [QW-1:0]                   q;
        logic signed [sqvt_pkg::TC_W-1:0] qs;
        q  = acc_reg[ST-1];
        qs = sqvt_pkg::TC_W'(q);
        if (q > QW'(sqvt_pkg::TC_MAX))
        begin
            quot = neg_reg[ST-1] ? sqvt_pkg::TC_MIN : sqvt_pkg::TC_MAX;
        end
        else
        begin
            quot = neg_reg[ST-1] ? -qs : qs;
        end
    end

endmodule

/* hw/rtl/sprite_quad_vertex_transform.sv */
// Sprite quad vertex setup. Each accepted request yields four vertices (top-left, top-right,
// bottom-left, bottom-right) one per cycle unless out_stall holds the lane; a new quad is taken
// as the last corner issues. The rate is set by the single vertex lane that all four corners
// share. Positions wait in carry registers for the 8-stage texture divider. out_stall
// freezes the whole lane while out_valid is high. Register writes are taken at any time
// (cfg_ready is tied high) but must only be made with no quad in flight; the sine table holds
// SINE_TABLE_DEPTH entries (power of two).
module sprite_quad_vertex_transform
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [23:0]  dest_x,
    input  logic signed [23:0]  dest_y,
    input  logic signed [23:0]  dest_w,
    input  logic signed [23:0]  dest_h,
    input  logic [12:0]         tex_width,
    input  logic [12:0]         tex_height,
    input  logic [12:0]         src_x,
    input  logic [12:0]         src_y,
    input  logic signed [13:0]  src_w,
    input  logic signed [13:0]  src_h,
    input  logic                use_affine,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          vertex_index,
    output logic signed [23:0]  pos_x,
    output logic signed [23:0]  pos_y,
    output logic signed [20:0]  tex_u,
    output logic signed [20:0]  tex_v,
    output logic [31:0]         color_out,
    output logic                last_vertex
);

    localparam int NCARRY = 5;

    // configuration
    logic [15:0]        rot_angle_reg;
    logic signed [23:0] rot_cx_reg;
    logic signed [23:0] rot_cy_reg;
    logic signed [15:0] scale_x_reg;
    logic signed [15:0] scale_y_reg;
    logic signed [23:0] scale_cx_reg;
    logic signed [23:0] scale_cy_reg;
    logic [31:0]        color_reg;

    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;
    logic signed [40:0] rox_reg;
    logic signed [40:0] roy_reg;
    logic [sqvt_pkg::SIN_IDX_W-1:0] sin_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_angle_reg <= '0;
            rot_cx_reg    <= '0;
            rot_cy_reg    <= '0;
            scale_x_reg   <= 16'sd256;
            scale_y_reg   <= 16'sd256;
            scale_cx_reg  <= '0;
            scale_cy_reg  <= '0;
            color_reg     <= 32'hFFFF_FFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (sqvt_pkg::cfg_reg_t'(cfg_index))
                sqvt_pkg::REG_ROT_ANGLE:      rot_angle_reg <= cfg_data[15:0];
                sqvt_pkg::REG_ROT_CENTER_X:   rot_cx_reg    <= cfg_data[23:0];
                sqvt_pkg::REG_ROT_CENTER_Y:   rot_cy_reg    <= cfg_data[23:0];
                sqvt_pkg::REG_SCALE_X:        scale_x_reg   <= cfg_data[15:0];
                sqvt_pkg::REG_SCALE_Y:        scale_y_reg   <= cfg_data[15:0];
                sqvt_pkg::REG_SCALE_CENTER_X: scale_cx_reg  <= cfg_data[23:0];
                sqvt_pkg::REG_SCALE_CENTER_Y: scale_cy_reg  <= cfg_data[23:0];
                sqvt_pkg::REG_VERTEX_COLOR:   color_reg     <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // values that follow the registers only, refreshed every cycle
    assign sin_idx = rot_angle_reg[15 -: sqvt_pkg::SIN_IDX_W];

    always_ff @(posedge clk)
    begin
        sin_reg <= sqvt_pkg::SIN_TAB[sin_idx];
        cos_reg <= sqvt_pkg::SIN_TAB[sin_idx +
                   sqvt_pkg::SIN_IDX_W'(sqvt_pkg::SINE_TABLE_DEPTH / 4)];
        rox_reg <= (rot_cx_reg - scale_cx_reg) * scale_x_reg;
        roy_reg <= (rot_cy_reg - scale_cy_reg) * scale_y_reg;
    end

    // request holding register and corner sequencer
    logic               item_vld_reg;
    logic               item_vld_next;
    logic [1:0]         k_reg;
    logic [1:0]         k_next;
    logic signed [23:0] it_dx_reg;
    logic signed [23:0] it_dy_reg;
    logic signed [23:0] it_dw_reg;
    logic signed [23:0] it_dh_reg;
    logic [12:0]        it_tw_reg;
    logic [12:0]        it_th_reg;
    logic [12:0]        it_sx_reg;
    logic [12:0]        it_sy_reg;
    logic signed [13:0] it_sw_reg;
    logic signed [13:0] it_sh_reg;
    logic               it_aff_reg;

    logic adv;
    logic issue;
    logic last_issue;
    logic accept;

    logic [9:1] vld_reg;
    logic       out_vld_reg;

    assign adv        = !(out_vld_reg && out_stall);
    assign issue      = item_vld_reg && adv;
    assign last_issue = issue && (k_reg == 2'd3);
    assign in_stall   = item_vld_reg && !last_issue;
    assign accept     = in_valid && !in_stall;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        k_next        = k_reg;
        if (issue)
        begin
            k_next = k_reg + 2'd1;
        end
        if (accept)
        begin
            item_vld_next = 1'b1;
        end
        else if (last_issue)
        begin
            item_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            k_reg        <= '0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            it_dx_reg  <= dest_x;
            it_dy_reg  <= dest_y;
            it_dw_reg  <= dest_w;
            it_dh_reg  <= dest_h;
            it_tw_reg  <= tex_width;
            it_th_reg  <= tex_height;
            it_sx_reg  <= src_x;
            it_sy_reg  <= src_y;
            it_sw_reg  <= src_w;
            it_sh_reg  <= src_h;
            it_aff_reg <= use_affine;
        end
    end

    // stage 1: corner select, plain sums, span products, divider operands
    logic [1:0]         p1_idx_reg;
    logic               p1_aff_reg;
    logic [31:0]        p1_color_reg;
    logic signed [23:0] p1_dx_reg;
    logic signed [23:0] p1_dy_reg;
    logic signed [25:0] p1_pxpl_reg;
    logic signed [25:0] p1_pypl_reg;
    logic signed [29:0] p1_mx_reg;
    logic signed [29:0] p1_my_reg;
    logic signed [15:0] p1_nu_reg;
    logic signed [15:0] p1_nv_reg;
    logic [12:0]        p1_tw_reg;
    logic [12:0]        p1_th_reg;

    logic signed [15:0] sx_ext;
    logic signed [15:0] sy_ext;

    assign sx_ext = $signed({3'b000, it_sx_reg});
    assign sy_ext = $signed({3'b000, it_sy_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_idx_reg   <= k_reg;
            p1_aff_reg   <= it_aff_reg;
            p1_color_reg <= color_reg;
            p1_dx_reg    <= it_dx_reg;
            p1_dy_reg    <= it_dy_reg;
            p1_pxpl_reg  <= it_dx_reg - 26'sd128 + (k_reg[0] ? it_dw_reg : 24'sd0);
            p1_pypl_reg  <= it_dy_reg - 26'sd128 + (k_reg[1] ? it_dh_reg : 24'sd0);
            p1_mx_reg    <= k_reg[0] ? it_sw_reg * scale_x_reg : 30'sd0;
            p1_my_reg    <= k_reg[1] ? it_sh_reg * scale_y_reg : 30'sd0;
            p1_nu_reg    <= sx_ext + (k_reg[0] ? it_sw_reg : 14'sd0);
            p1_nv_reg    <= sy_ext + (k_reg[1] ? it_sh_reg : 14'sd0);
            p1_tw_reg    <= it_tw_reg;
            p1_th_reg    <= it_th_reg;
        end
    end

    // stage 2: corner offsets from the rotation centre, origin term
    sqvt_pkg::meta_t    p2_meta_reg;
    logic signed [41:0] p2_xk_reg;
    logic signed [41:0] p2_yk_reg;
    logic signed [59:0] p2_ox_reg;
    logic signed [59:0] p2_oy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_meta_reg.idx   <= p1_idx_reg;
            p2_meta_reg.aff   <= p1_aff_reg;
            p2_meta_reg.color <= p1_color_reg;
            p2_meta_reg.px_pl <= sqvt_pkg::sat_pos(60'(p1_pxpl_reg));
            p2_meta_reg.py_pl <= sqvt_pkg::sat_pos(60'(p1_pypl_reg));
            p2_xk_reg <= (p1_mx_reg <<< 8) - rox_reg;
            p2_yk_reg <= (p1_my_reg <<< 8) - roy_reg;
            p2_ox_reg <= (p1_dx_reg <<< 22) + (rox_reg <<< 14) - (60'sd1 <<< 29);
            p2_oy_reg <= (p1_dy_reg <<< 22) + (roy_reg <<< 14) - (60'sd1 <<< 29);
        end
    end

    // stage 3: rotation products
    sqvt_pkg::meta_t    p3_meta_reg;
    logic signed [57:0] p3_xc_reg;
    logic signed [57:0] p3_ys_reg;
    logic signed [57:0] p3_xs_reg;
    logic signed [57:0] p3_yc_reg;
    logic signed [59:0] p3_ox_reg;
    logic signed [59:0] p3_oy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_meta_reg <= p2_meta_reg;
            p3_xc_reg   <= p2_xk_reg * cos_reg;
            p3_ys_reg   <= p2_yk_reg * sin_reg;
            p3_xs_reg   <= p2_xk_reg * sin_reg;
            p3_yc_reg   <= p2_yk_reg * cos_reg;
            p3_ox_reg   <= p2_ox_reg;
            p3_oy_reg   <= p2_oy_reg;
        end
    end

    // stage 4: rotated sums
    sqvt_pkg::meta_t    p4_meta_reg;
    logic signed [59:0] p4_x_reg;
    logic signed [59:0] p4_y_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_meta_reg <= p3_meta_reg;
            p4_x_reg    <= p3_xc_reg - p3_ys_reg + p3_ox_reg;
            p4_y_reg    <= p3_xs_reg + p3_yc_reg + p3_oy_reg;
        end
    end

    // stage 5: round half up to Q.8, saturate, pick mode
    sqvt_pkg::vtx_t     p5_next;
    sqvt_pkg::vtx_t     carry_reg [NCARRY];
    logic signed [59:0] xr;
    logic signed [59:0] yr;

    always_comb
    begin
        xr = (p4_x_reg + (60'sd1 <<< 21)) >>> 22;
        yr = (p4_y_reg + (60'sd1 <<< 21)) >>> 22;
        p5_next.idx   = p4_meta_reg.idx;
        p5_next.color = p4_meta_reg.color;
        if (p4_meta_reg.aff)
        begin
            p5_next.px = sqvt_pkg::sat_pos(xr);
            p5_next.py = sqvt_pkg::sat_pos(yr);
        end
        else
        begin
            p5_next.px = p4_meta_reg.px_pl;
            p5_next.py = p4_meta_reg.py_pl;
        end
    end

    // stages 5..9 wait for the divider
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            carry_reg[0] <= p5_next;
            for (int i = 1; i < NCARRY; i++)
            begin
                carry_reg[i] <= carry_reg[i-1];
            end
        end
    end

    logic signed [20:0] quot_u;
    logic signed [20:0] quot_v;

    sqvt_div u_div_u
    (
        .clk  (clk),
        .en   (adv),
        .num  (p1_nu_reg),
        .size (p1_tw_reg),
        .quot (quot_u)
    );

    sqvt_div u_div_v
    (
        .clk  (clk),
        .en   (adv),
        .num  (p1_nv_reg),
        .size (p1_th_reg),
        .quot (quot_v)
    );

    // valid bits follow the lane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[8:1], issue};
            out_vld_reg <= vld_reg[9];
        end
    end

    // output register
    logic [1:0]         o_idx_reg;
    logic signed [23:0] o_px_reg;
    logic signed [23:0] o_py_reg;
    logic signed [20:0] o_u_reg;
    logic signed [20:0] o_v_reg;
    logic [31:0]        o_color_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_idx_reg   <= carry_reg[NCARRY-1].idx;
            o_px_reg    <= carry_reg[NCARRY-1].px;
            o_py_reg    <= carry_reg[NCARRY-1].py;
            o_color_reg <= carry_reg[NCARRY-1].color;
            o_u_reg     <= quot_u;
            o_v_reg     <= quot_v;
        end
    end

    assign out_valid    = out_vld_reg;
    assign vertex_index = o_idx_reg;
    assign pos_x        = o_px_reg;
    assign pos_y        = o_py_reg;
    assign tex_u        = o_u_reg;
    assign tex_v        = o_v_reg;
    assign color_out    = o_color_reg;
    assign last_vertex  = (o_idx_reg == 2'd3);

endmodule
